/* design/status_register_transfer_macros.svh */
// Assertion macros for the status register transfer block.
// Used by the top level only; needs a clock named clk and a reset named rst.
`ifndef STATUS_REGISTER_TRANSFER_MACROS_SVH
`define STATUS_REGISTER_TRANSFER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SRT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SRT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/srt_pkg.sv */
// Shared types, constants and mask tables for the status register transfer block.
// No dependencies; imported by every module of the block.
package srt_pkg;

  localparam int PSR_W      = 32;
  localparam int SPSR_BANKS = 5;
  localparam int BANK_W     = $clog2(SPSR_BANKS);
  localparam int ROW_W      = 3;

  localparam logic [PSR_W-1:0] CPSR_RESET = 32'h0000_00d3;
  localparam logic [ROW_W-1:0] ARCH_RESET = 3'd4;
  localparam logic [ROW_W-1:0] ARCH_MAX   = 3'd4;
  localparam int               TBIT_POS   = 5;

  localparam logic [4:0] MODE_USR = 5'h10;
  localparam logic [4:0] MODE_FIQ = 5'h11;
  localparam logic [4:0] MODE_IRQ = 5'h12;
  localparam logic [4:0] MODE_SVC = 5'h13;
  localparam logic [4:0] MODE_ABT = 5'h17;
  localparam logic [4:0] MODE_UND = 5'h1b;

  localparam logic CMD_MRS = 1'b0;
  localparam logic CMD_MSR = 1'b1;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_UNPRED = 2'd1,
    ST_UNIMPL = 2'd2
  } status_t;

  typedef struct packed {
    logic             cmd;
    logic [PSR_W-1:0] instr;
    logic [PSR_W-1:0] rm_value;
    logic             cond_pass;
  } item_t;

  typedef struct packed {
    status_t          status;
    logic [PSR_W-1:0] psr_value;
    logic             rd_write;
    logic [3:0]       rd_index;
    logic             thumb_changed;
  } result_t;

  // Current view of the status registers, as seen by the execute logic.
  typedef struct packed {
    logic [PSR_W-1:0] cpsr;
    logic [PSR_W-1:0] spsr;
    logic             has_spsr;
    logic [ROW_W-1:0] row;
  } psr_view_t;

  typedef struct packed {
    logic             cpsr_we;
    logic             spsr_we;
    logic [PSR_W-1:0] value;
  } psr_write_t;

  typedef struct packed {
    logic              valid;
    logic [BANK_W-1:0] idx;
  } bank_sel_t;

  function automatic bank_sel_t bank_of_mode(input logic [4:0] mode);
    bank_sel_t b;
    b.valid = 1'b1;
    unique case (mode)
      MODE_FIQ: b.idx = BANK_W'(0);
      MODE_IRQ: b.idx = BANK_W'(1);
      MODE_SVC: b.idx = BANK_W'(2);
      MODE_ABT: b.idx = BANK_W'(3);
      MODE_UND: b.idx = BANK_W'(4);
      default: begin
        b.valid = 1'b0;
        b.idx   = '0;
      end
    endcase
    return b;
  endfunction

  function automatic logic [PSR_W-1:0] priv_bits(input logic [ROW_W-1:0] row);
    case (row)
      3'd0, 3'd1, 3'd2, 3'd3: return 32'h0000_000f;
      default:                return 32'h0000_01df;
    endcase
  endfunction

  function automatic logic [PSR_W-1:0] exec_state_bits(input logic [ROW_W-1:0] row);
    case (row)
      3'd0:       return 32'h0000_0000;
      3'd1, 3'd2: return 32'h0000_0020;
      default:    return 32'h0100_0020;
    endcase
  endfunction

  function automatic logic [PSR_W-1:0] reserved_bits(input logic [ROW_W-1:0] row);
    case (row)
      3'd0:    return 32'h0fff_ff20;
      3'd1:    return 32'h0fff_ff00;
      3'd2:    return 32'h07ff_ff00;
      3'd3:    return 32'h06ff_ff00;
      default: return 32'h06f0_fc00;
    endcase
  endfunction

  function automatic logic [PSR_W-1:0] flag_bits(input logic [ROW_W-1:0] row);
    case (row)
      3'd0, 3'd1: return 32'hf000_0000;
      3'd2, 3'd3: return 32'hf800_0000;
      default:    return 32'hf80f_0200;
    endcase
  endfunction

endpackage

/* design/srt_psr_regs.sv */
// CPSR, the five banked SPSRs and the architecture version register.
// Depends on srt_pkg; written by the top level from the execute logic.
module srt_psr_regs (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [srt_pkg::ROW_W-1:0] cfg_value,
  input  srt_pkg::psr_write_t       wr,
  output srt_pkg::psr_view_t        view
);
  import srt_pkg::*;

  logic [PSR_W-1:0] cpsr;
  logic [PSR_W-1:0] spsr [SPSR_BANKS];
  logic [ROW_W-1:0] arch_version;
  bank_sel_t        bank;

  assign bank = bank_of_mode(cpsr[4:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cpsr         <= CPSR_RESET;
      arch_version <= ARCH_RESET;
      for (int i = 0; i < SPSR_BANKS; i++) begin
        spsr[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        arch_version <= cfg_value;
      end
      if (wr.cpsr_we) begin
        cpsr <= wr.value;
      end
      for (int i = 0; i < SPSR_BANKS; i++) begin
        if (wr.spsr_we && bank.valid && bank.idx == BANK_W'(i)) begin
          spsr[i] <= wr.value;
        end
      end
    end
  end

  always_comb begin
    view.cpsr     = cpsr;
    view.has_spsr = bank.valid;
    view.spsr     = bank.valid ? spsr[bank.idx] : '0;
    view.row      = (arch_version > ARCH_MAX) ? ARCH_MAX : arch_version;
  end

endmodule

/* design/srt_exec.sv */
// Decode and masking logic for one MRS or MSR instruction.
// Depends on srt_pkg; purely combinational, fed from the input register.
module srt_exec (
  input  srt_pkg::item_t     item,
  input  srt_pkg::psr_view_t view,
  output srt_pkg::result_t   res,
  output srt_pkg::psr_write_t wr
);
  import srt_pkg::*;

  logic [PSR_W-1:0]   ir;
  logic [PSR_W-1:0]   imm_op;
  logic [2*PSR_W-1:0] imm_dbl;
  logic [4:0]         rot;
  logic [PSR_W-1:0]   op;
  logic [PSR_W-1:0]   field_bytes;
  logic [PSR_W-1:0]   st, us, pr, ua;
  logic [PSR_W-1:0]   mask;
  logic [PSR_W-1:0]   value;
  logic               priv;
  logic               use_spsr;
  status_t            status;

  assign ir      = item.instr;
  assign rot     = {ir[11:8], 1'b0};
  assign imm_dbl = {24'd0, ir[7:0], 24'd0, ir[7:0]} >> rot;
  assign imm_op  = imm_dbl[PSR_W-1:0];
  assign st      = exec_state_bits(view.row);
  assign us      = flag_bits(view.row);
  assign pr      = priv_bits(view.row);
  assign ua      = reserved_bits(view.row);
  assign priv    = view.cpsr[4:0] != MODE_USR;
  assign use_spsr = ir[22];
  assign field_bytes = {{8{ir[19]}}, {8{ir[18]}}, {8{ir[17]}}, {8{ir[16]}}};

  always_comb begin
    status = ST_OK;
    value  = '0;
    op     = '0;
    mask   = '0;
    res.rd_write      = 1'b0;
    res.thumb_changed = 1'b0;
    wr.cpsr_we        = 1'b0;
    wr.spsr_we        = 1'b0;

    if (item.cmd == CMD_MRS) begin
      if (ir[19:16] != 4'hf || ir[11:0] != 12'd0) begin
        status = ST_UNPRED;
      end else begin
        value        = use_spsr ? view.spsr : view.cpsr;
        res.rd_write = item.cond_pass;
      end
    end else begin
      // Operand selection, in the order in which the checks take priority.
      if (ir[15:12] != 4'hf) begin
        status = ST_UNPRED;
      end else if (ir[25]) begin
        op = imm_op;
      end else if (ir[7:4] != 4'd0) begin
        status = ST_UNIMPL;
      end else if (ir[11:8] != 4'd0) begin
        status = ST_UNPRED;
      end else begin
        op = item.rm_value;
      end

      if (status == ST_OK && (op & ua) != '0) begin
        status = ST_UNPRED;
      end

      if (status == ST_OK) begin
        if (use_spsr) begin
          if (!view.has_spsr) begin
            status = ST_UNPRED;
          end else begin
            mask       = field_bytes & (us | pr | st);
            value      = (view.spsr & ~mask) | (op & mask);
            wr.spsr_we = item.cond_pass;
          end
        end else if (priv && (op & st) != '0) begin
          status = ST_UNPRED;
        end else begin
          mask       = priv ? (field_bytes & (us | pr)) : (field_bytes & us);
          value      = (view.cpsr & ~mask) | (op & mask);
          wr.cpsr_we = item.cond_pass;
          res.thumb_changed = item.cond_pass &
                              (view.cpsr[TBIT_POS] ^ value[TBIT_POS]);
        end
      end

      if (status != ST_OK) begin
        value = '0;
      end
    end

    res.status    = status;
    res.psr_value = value;
    res.rd_index  = ir[15:12];
    wr.value      = value;
  end

endmodule

/* design/status_register_transfer.sv */
// Top level of the MRS/MSR status register transfer block.
// Depends on srt_pkg, srt_psr_regs, srt_exec and the assertion macro header.
//
//  channel  | direction | words carried
//  ---------+-----------+-----------------------------------------------
//  s_*      | in        | one MRS or MSR instruction with operands
//  m_*      | out       | status, PSR value and Rd write request
//  cfg_*    | in        | architecture version (mask table row)
//
// An instruction executes in the cycle after it is accepted and its result is
// loaded at the next edge; one instruction per cycle is sustained while m_tready
// stays high. Synchronous reset clears both valid flags, loads CPSR with 0xD3,
// clears the SPSRs and selects table row 4. A stall on m_tready holds the result
// register and backs up into the input register one word later.
`include "status_register_transfer_macros.svh"

module status_register_transfer (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // [31:0] instr, [63:32] rm_value, [64] cond_pass, [71:65] zero
  input  logic [71:0]               s_tdata,
  // [0] cmd
  input  logic                      s_tuser,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // [31:0] psr_value, [32] rd_write, [36:33] rd_index, [37] thumb_changed,
  // [39:38] zero
  output logic [39:0]               m_tdata,
  // [1:0] status
  output logic [1:0]                m_tuser,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [srt_pkg::ROW_W-1:0] cfg_data
);
  import srt_pkg::*;

  logic       in_vld;
  item_t      in_item;
  logic       out_vld;
  result_t    out_res;
  logic       advance;
  result_t    res_next;
  psr_write_t wr_raw;
  psr_write_t wr;
  psr_view_t  view;

  // An instruction executes when the result register is free or emptying.
  assign advance   = in_vld && (!out_vld || m_tready);
  assign s_tready  = !in_vld || advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_tready) begin
      in_vld <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.cmd       <= s_tuser;
      in_item.instr     <= s_tdata[31:0];
      in_item.rm_value  <= s_tdata[63:32];
      in_item.cond_pass <= s_tdata[64];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (advance) begin
      out_vld <= 1'b1;
    end else if (m_tready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res_next;
    end
  end

  srt_exec u_exec (
    .item (in_item),
    .view (view),
    .res  (res_next),
    .wr   (wr_raw)
  );

  always_comb begin
    wr         = wr_raw;
    wr.cpsr_we = wr_raw.cpsr_we && advance;
    wr.spsr_we = wr_raw.spsr_we && advance;
  end

  srt_psr_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_value (cfg_data),
    .wr        (wr),
    .view      (view)
  );

  assign m_tvalid = out_vld;
  assign m_tuser  = out_res.status;
  assign m_tdata  = {2'b00, out_res.thumb_changed, out_res.rd_index,
                     out_res.rd_write, out_res.psr_value};

  `SRT_ASSERT_IMPL(a_err_clears_result,
    out_vld && out_res.status != ST_OK,
    out_res.psr_value == '0 && !out_res.rd_write,
    "result with error status carries data or an Rd write")

  `SRT_ASSERT_IMPL(a_write_only_when_ok,
    wr.cpsr_we || wr.spsr_we,
    res_next.status == ST_OK && in_item.cond_pass && in_item.cmd == CMD_MSR,
    "status register written by a failed or skipped instruction")

  `SRT_ASSERT_IMPL(a_thumb_needs_cpsr_write,
    advance && res_next.thumb_changed,
    wr.cpsr_we && !wr.spsr_we,
    "T bit change reported without a CPSR write")

  `SRT_ASSERT_NEXT(a_cpsr_follows_write,
    wr.cpsr_we,
    view.cpsr == $past(wr.value),
    "CPSR does not hold the value written")

endmodule

/* dv/status_register_transfer_tb.sv */
// Self-checking testbench for the MRS/MSR status register transfer block.
// Needs srt_pkg and status_register_transfer; drives both stream sides and the
// configuration channel, and checks every result word against its own predictor.
`timescale 1ns / 1ps

module status_register_transfer_tb;
  import srt_pkg::*;

  localparam logic [4:0] MODE_SYS    = 5'h1f;
  localparam int         IDLE_PCT    = 26;
  localparam int         HOLD_CYCLES = 120;
  localparam int         QUIET_LIMIT = 2000;

  typedef struct packed {
    logic [PSR_W-1:0] priv;
    logic [PSR_W-1:0] state;
    logic [PSR_W-1:0] unalloc;
    logic [PSR_W-1:0] user;
  } mask_set_t;

  typedef struct packed {
    logic [PSR_W-1:0]                 cpsr;
    logic [SPSR_BANKS-1:0][PSR_W-1:0] spsr;
  } psr_file_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [71:0]       s_tdata = '0;   // [31:0] instr, [63:32] rm_value, [64] cond_pass
  logic              s_tuser = 1'b0; // [0] cmd
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [39:0]       m_tdata;        // [31:0] psr_value, [32] rd_write, [36:33] rd_index,
                                     // [37] thumb_changed
  logic [1:0]        m_tuser;        // [1:0] status
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [ROW_W-1:0]  cfg_data = '0;

  // Predictor state, advanced at every accepted word.
  psr_file_t         psr_file;
  logic [ROW_W-1:0]  arch_reg;
  result_t           pending_results[$];

  int unsigned       fail_count = 0;
  int unsigned       quiet_cycles = 0;
  int                hold_left = 0;
  logic              stall_req = 1'b0;
  logic              stall_done = 1'b0;
  logic              no_idle = 1'b0;
  logic              allow_user = 1'b0;

  status_register_transfer u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mask rows per architecture version; anything above 4 behaves as 4.
  function automatic mask_set_t arch_masks(input logic [ROW_W-1:0] row);
    mask_set_t m;
    case (row)
      3'd0: m = '{32'h0000_000f, 32'h0000_0000, 32'h0fff_ff20, 32'hf000_0000};
      3'd1: m = '{32'h0000_000f, 32'h0000_0020, 32'h0fff_ff00, 32'hf000_0000};
      3'd2: m = '{32'h0000_000f, 32'h0000_0020, 32'h07ff_ff00, 32'hf800_0000};
      3'd3: m = '{32'h0000_000f, 32'h0100_0020, 32'h06ff_ff00, 32'hf800_0000};
      default: m = '{32'h0000_01df, 32'h0100_0020, 32'h06f0_fc00, 32'hf80f_0200};
    endcase
    return m;
  endfunction

  // Executes one MRS or MSR on the register file cur; nxt is the file afterwards.
  function automatic result_t exec_psr_transfer(input item_t it,
                                                input logic [ROW_W-1:0] row,
                                                input psr_file_t cur,
                                                output psr_file_t nxt);
    result_t          r;
    mask_set_t        m;
    logic [PSR_W-1:0] ir;
    logic [PSR_W-1:0] op;
    logic [PSR_W-1:0] bm;
    logic [PSR_W-1:0] wmask;
    logic [PSR_W-1:0] newv;
    logic [63:0]      rot;
    int               bank;
    logic             priv;
    m = arch_masks(row);
    ir = it.instr;
    nxt = cur;
    op = '0;
    bm = '0;
    r.status = ST_OK;
    r.psr_value = '0;
    r.rd_write = 1'b0;
    r.rd_index = ir[15:12];
    r.thumb_changed = 1'b0;
    case (cur.cpsr[4:0])
      MODE_FIQ: bank = 0;
      MODE_IRQ: bank = 1;
      MODE_SVC: bank = 2;
      MODE_ABT: bank = 3;
      MODE_UND: bank = 4;
      default:  bank = -1;
    endcase
    priv = cur.cpsr[4:0] != MODE_USR;
    if (it.cmd == CMD_MRS) begin
      if (ir[19:16] != 4'hf || ir[11:0] != 12'h0) begin
        r.status = ST_UNPRED;
      end else begin
        if (!ir[22]) r.psr_value = cur.cpsr;
        else if (bank >= 0) r.psr_value = cur.spsr[bank];
        r.rd_write = it.cond_pass;
      end
    end else begin
      if (ir[15:12] != 4'hf) begin
        r.status = ST_UNPRED;
      end else if (ir[25]) begin
        rot = {24'h0, ir[7:0], 24'h0, ir[7:0]} >> {ir[11:8], 1'b0};
        op = rot[31:0];
      end else if (ir[7:4] != 4'h0) begin
        r.status = ST_UNIMPL;
      end else if (ir[11:8] != 4'h0) begin
        r.status = ST_UNPRED;
      end else begin
        op = it.rm_value;
      end
      if (r.status == ST_OK && (op & m.unalloc) != '0) r.status = ST_UNPRED;
      for (int k = 0; k < 4; k++) bm[8*k +: 8] = {8{ir[16+k]}};
      if (r.status == ST_OK) begin
        if (ir[22]) begin
          if (bank < 0) begin
            r.status = ST_UNPRED;
          end else begin
            wmask = bm & (m.user | m.priv | m.state);
            newv = (cur.spsr[bank] & ~wmask) | (op & wmask);
            r.psr_value = newv;
            if (it.cond_pass) nxt.spsr[bank] = newv;
          end
        end else if (priv && (op & m.state) != '0) begin
          r.status = ST_UNPRED;
        end else begin
          wmask = priv ? (bm & (m.user | m.priv)) : (bm & m.user);
          newv = (cur.cpsr & ~wmask) | (op & wmask);
          r.psr_value = newv;
          if (it.cond_pass) begin
            r.thumb_changed = cur.cpsr[TBIT_POS] ^ newv[TBIT_POS];
            nxt.cpsr = newv;
          end
        end
      end
    end
    return r;
  endfunction

  function automatic logic [31:0] mrs_word(input logic spsr_sel);
    return 32'he10f_0000 | {9'b0, spsr_sel, 22'b0};
  endfunction

  function automatic logic [31:0] msr_reg_word(input logic spsr_sel, input logic [3:0] fields);
    return 32'he120_f000 | {9'b0, spsr_sel, 2'b0, fields, 16'b0};
  endfunction

  function automatic logic [31:0] msr_imm_word(input logic spsr_sel, input logic [3:0] fields,
                                               input logic [3:0] rot, input logic [7:0] imm);
    return 32'he320_f000 | {9'b0, spsr_sel, 2'b0, fields, 4'b0, rot, imm};
  endfunction

  // Mostly well-formed instructions with random content; raw noise otherwise.
  function automatic item_t gen_instr(input bit clean);
    item_t            it;
    mask_set_t        m;
    logic [PSR_W-1:0] op;
    m = arch_masks(arch_reg);
    it.cmd = 1'($urandom_range(1));
    it.instr = $urandom;
    it.rm_value = $urandom;
    it.cond_pass = $urandom_range(99) < 85;
    if (clean) begin
      if (it.cmd == CMD_MRS) begin
        it.instr[19:16] = 4'hf;
        it.instr[11:0] = 12'h0;
      end else begin
        it.instr[15:12] = 4'hf;
        op = $urandom & ~m.unalloc;
        if (!it.instr[22] && psr_file.cpsr[4:0] != MODE_USR) op &= ~m.state;
        if (!it.instr[22] && it.instr[16]) begin
          case ($urandom_range(6))
            0: op[4:0] = MODE_FIQ;
            1: op[4:0] = MODE_IRQ;
            2: op[4:0] = MODE_SVC;
            3: op[4:0] = MODE_ABT;
            4: op[4:0] = MODE_UND;
            5: op[4:0] = MODE_SYS;
            default: op[4:0] = 5'($urandom_range(31));
          endcase
        end
        if ($urandom_range(3) == 0) begin
          it.instr[25] = 1'b1;
        end else begin
          it.instr[25] = 1'b0;
          it.instr[11:4] = 8'h0;
          it.rm_value = op;
        end
      end
    end
    return it;
  endfunction

  task automatic send_instr(input logic cmd, input logic [31:0] instr,
                            input logic [31:0] rm_value, input logic cond_pass);
    item_t     it;
    psr_file_t nxt;
    it.cmd = cmd;
    it.instr = instr;
    it.rm_value = rm_value;
    it.cond_pass = cond_pass;
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {7'h0, cond_pass, rm_value, instr};
    s_tuser <= cmd;
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(exec_psr_transfer(it, arch_reg, psr_file, nxt));
    psr_file = nxt;
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_arch(input logic [ROW_W-1:0] row);
    cfg_valid <= 1'b1;
    cfg_data <= row;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    arch_reg = row;
  endtask

  task automatic run_random(input int count);
    item_t     it;
    psr_file_t probe;
    repeat (count) begin
      // Leaving user mode takes a reset, so user mode is kept for the last phase.
      forever begin
        it = gen_instr($urandom_range(99) < 80);
        void'(exec_psr_transfer(it, arch_reg, psr_file, probe));
        if (allow_user || probe.cpsr[4:0] != MODE_USR) break;
      end
      send_instr(it.cmd, it.instr, it.rm_value, it.cond_pass);
    end
  endtask

  task automatic test_mrs_directed();
    send_instr(CMD_MRS, mrs_word(1'b0), 32'h0, 1'b1);
    send_instr(CMD_MRS, mrs_word(1'b1), 32'hffff_ffff, 1'b1);
    send_instr(CMD_MRS, mrs_word(1'b0) & ~32'h0001_0000, 32'h0, 1'b1);
    send_instr(CMD_MRS, mrs_word(1'b0) | 32'h0000_0001, 32'h0, 1'b1);
    send_instr(CMD_MRS, mrs_word(1'b0) | 32'h0000_0800, 32'h0, 1'b1);
    send_instr(CMD_MRS, mrs_word(1'b1), 32'h0, 1'b0);
    send_instr(CMD_MRS, 32'hffff_ffff, 32'hffff_ffff, 1'b1);
    send_instr(CMD_MRS, 32'h0000_0000, 32'h0000_0000, 1'b0);
    wait_idle();
  endtask

  task automatic test_msr_directed();
    // Every writable SPSR bit, then read back.
    send_instr(CMD_MSR, msr_reg_word(1'b1, 4'hf), ~32'h06f0_fc00, 1'b1);
    send_instr(CMD_MRS, mrs_word(1'b1), 32'h0, 1'b1);
    // Flags through a rotated immediate.
    send_instr(CMD_MSR, msr_imm_word(1'b0, 4'h8, 4'h4, 8'hf0), 32'h0, 1'b1);
    send_instr(CMD_MSR, msr_reg_word(1'b0, 4'h8) | 32'h0000_0010, 32'h0, 1'b1);
    send_instr(CMD_MSR, msr_reg_word(1'b0, 4'h8) | 32'h0000_0100, 32'h0, 1'b1);
    send_instr(CMD_MSR, msr_reg_word(1'b0, 4'h8) & ~32'h0000_1000, 32'h0, 1'b1);
    send_instr(CMD_MSR, msr_reg_word(1'b0, 4'hf), 32'h0000_0400, 1'b1);
    send_instr(CMD_MSR, msr_reg_word(1'b0, 4'h1), 32'h0000_00f3, 1'b1);
    send_instr(CMD_MSR, msr_reg_word(1'b0, 4'h1), {27'h0, MODE_SYS}, 1'b0);
    send_instr(CMD_MSR, msr_reg_word(1'b0, 4'h1), {24'h0, 3'b110, MODE_SYS}, 1'b1);
    send_instr(CMD_MRS, mrs_word(1'b1), 32'h0, 1'b1);
    send_instr(CMD_MSR, msr_reg_word(1'b1, 4'hf), 32'h0000_0000, 1'b1);
    send_instr(CMD_MSR, msr_reg_word(1'b0, 4'h1), {24'h0, 3'b110, MODE_FIQ}, 1'b1);
    send_instr(CMD_MRS, mrs_word(1'b1), 32'h0, 1'b1);
    // The T bit may go into an SPSR but not into the CPSR.
    send_instr(CMD_MSR, msr_reg_word(1'b1, 4'h1), 32'h0000_0020, 1'b1);
    send_instr(CMD_MSR, msr_reg_word(1'b0, 4'hf), 32'hffff_ffff, 1'b1);
    send_instr(CMD_MSR, msr_reg_word(1'b0, 4'h0), 32'h0000_0000, 1'b1);
    send_instr(CMD_MSR, msr_reg_word(1'b0, 4'h1), {24'h0, 3'b110, MODE_SVC}, 1'b1);
    wait_idle();
  endtask

  task automatic test_arch_rows();
    for (int r = 0; r < 8; r++) begin
      if (r != ARCH_RESET) begin
        write_arch(ROW_W'(r));
        run_random(60);
        wait_idle();
      end
    end
    // Back to the reset row, with both sides running flat out.
    write_arch(ARCH_RESET);
    no_idle <= 1'b1;
    run_random(60);
    wait_idle();
    no_idle <= 1'b0;
  endtask

  task automatic test_backpressure();
    stall_req <= 1'b1;
    no_idle <= 1'b1;
    run_random(40);
    wait_idle();
    no_idle <= 1'b0;
  endtask

  task automatic test_user_mode();
    allow_user = 1'b1;
    send_instr(CMD_MSR, msr_reg_word(1'b0, 4'h1), {27'h0, MODE_USR}, 1'b1);
    send_instr(CMD_MRS, mrs_word(1'b1), 32'h0, 1'b1);
    send_instr(CMD_MSR, msr_reg_word(1'b0, 4'h8), 32'hf800_0000, 1'b1);
    send_instr(CMD_MSR, msr_reg_word(1'b0, 4'h1), 32'h0000_0033, 1'b1);
    send_instr(CMD_MSR, msr_reg_word(1'b1, 4'h8), 32'h0000_0000, 1'b1);
    send_instr(CMD_MRS, mrs_word(1'b0), 32'h0, 1'b1);
    run_random(50);
    wait_idle();
  endtask

  function automatic void check_field(input string what, input logic [31:0] exp_v,
                                      input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, exp_v, act_v);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result word with nothing expected, actual status %0d psr 0x%0h",
                 $time, m_tuser, m_tdata[31:0]);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", 32'(want.status), 32'(m_tuser));
        check_field("psr_value", want.psr_value, m_tdata[31:0]);
        check_field("rd_write", 32'(want.rd_write), 32'(m_tdata[32]));
        check_field("rd_index", 32'(want.rd_index), 32'(m_tdata[36:33]));
        check_field("thumb_changed", 32'(want.thumb_changed), 32'(m_tdata[37]));
      end
    end
  end

  // Result side: random stalls, plus one long hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (stall_req && !stall_done) begin
      stall_done <= 1'b1;
      hold_left = HOLD_CYCLES;
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= no_idle || $urandom_range(99) >= IDLE_PCT;
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("status_register_transfer verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    psr_file.cpsr = CPSR_RESET;
    psr_file.spsr = '0;
    arch_reg = ARCH_RESET;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_mrs_directed();
    test_msr_directed();
    test_arch_rows();
    test_backpressure();
    test_user_mode();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("status_register_transfer verification clean");
    end else begin
      $display("status_register_transfer verification failed");
    end
    $finish;
  end

endmodule
